[rtl/core/assert_macros.svh]
// assertion helpers for the core
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_IMPLIES(label, clk, rst_n, a, c) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
        else $error("assertion failed");
`define ASSERT_NEXT(label, clk, rst_n, a, c) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
        else $error("assertion failed");
`else
`define ASSERT_IMPLIES(label, clk, rst_n, a, c)
`define ASSERT_NEXT(label, clk, rst_n, a, c)
`endif
`endif

[rtl/core/bpo_pkg.sv]
// ----------------------------------------------------------------------------
// bpo_pkg
// shared types and constants of the byte patch overlay
// ----------------------------------------------------------------------------
package bpo_pkg;
    localparam int PATCH_DEPTH = 64;
    localparam int UNDO_DEPTH  = 64;
    localparam int MAX_RUN     = 256;
    localparam int PW  = $clog2(PATCH_DEPTH);
    localparam int UW  = $clog2(UNDO_DEPTH);
    localparam int CW  = PW + 1;
    localparam int LCW = UW + 1;
    localparam int RW  = $clog2(MAX_RUN + 1);
    localparam int OFW = 63;
    localparam int EW  = OFW + 16;

    typedef enum logic [1:0] {
        F_READ  = 2'd0,
        F_EDIT  = 2'd1,
        F_UNDO  = 2'd2,
        F_FLUSH = 2'd3
    } t_func;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_UNAV  = 2'd1,
        ST_ERR   = 2'd2,
        ST_EMPTY = 2'd3
    } t_status;

    localparam logic ADDR_RO   = 1'b0;
    localparam logic ADDR_SIZE = 1'b1;

    // packed patch entry: offset, original, value
    typedef struct packed {
        logic [OFW-1:0] off;
        logic [7:0]     orig;
        logic [7:0]     val;
    } t_entry;

    typedef struct packed {
        logic [OFW-1:0] off;
        logic [7:0]     prior;
        logic [7:0]     orig;
    } t_log;
endpackage

[rtl/core/bpo_ram.sv]
// ----------------------------------------------------------------------------
// bpo_ram
// generic simple dual port ram (one write port, one read port) with registered read
// ----------------------------------------------------------------------------
module bpo_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

[rtl/core/byte_patch_overlay_with_undo.sv]
// ----------------------------------------------------------------------------
// byte_patch_overlay_with_undo
// sorted byte patch table with undo log, read, edit, undo and flush
// ----------------------------------------------------------------------------
// channel | dir | handshake            | payload
// in      | in  | i_valid / o_stall    | func offset new_byte base_byte base_status
// out     | out | o_valid / i_stall    | status data_byte flush_offset run_start last
//         |     |                      | pending_count
// cfg     | in  | apb psel/penable     | read_only_mode, store_size
// a read runs a binary search of k = ceil(log2(n+1)) search steps on the table ram;
// an edit or undo also shifts entries on insert or delete, each by a read and a write.
// a flush reads each patch from the table ram port in turn: read, wait, emit.
// reset is synchronous; the tables need no clearing, only their counts reset.
// input stalls while an item is in work or a result beat is held;
// a held result stalls the sequencer.
`include "assert_macros.svh"
module byte_patch_overlay_with_undo import bpo_pkg::*; (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_stall,
    input  logic [1:0]      i_func,
    input  logic [OFW-1:0]  i_offset,
    input  logic [7:0]      i_new_byte,
    input  logic [7:0]      i_base_byte,
    input  logic [1:0]      i_base_status,
    output logic            o_valid,
    input  logic            i_stall,
    output logic [1:0]      o_status,
    output logic [7:0]      o_data_byte,
    output logic [OFW-1:0]  o_flush_offset,
    output logic            o_run_start,
    output logic            o_last,
    output logic [6:0]      o_pending_count,
    input  logic            psel,
    input  logic            penable,
    input  logic            pwrite,
    input  logic [3:0]      paddr,
    input  logic [63:0]     pwdata,
    output logic [63:0]     prdata,
    output logic            pready
);
    typedef enum logic [4:0] {
        S_IDLE, S_SRCH, S_SRD, S_SCHK, S_HRD, S_HCHK, S_DEC, S_LRD, S_LWAIT,
        S_UDEC, S_UPD, S_DELRD, S_DELWR, S_INSRD, S_INSWR, S_INSPUT,
        S_FRD, S_FWAIT, S_FEMIT, S_OUT
    } t_state;

    t_state          r_state;
    logic            r_ro;
    logic [63:0]     r_size;
    logic [1:0]      r_func;
    logic [OFW-1:0]  r_off;
    logic [7:0]      r_nb, r_bb;
    logic [1:0]      r_bs;
    logic [CW-1:0]   r_ecnt;
    logic [LCW-1:0]  r_lcnt;
    logic [CW-1:0]   r_lo, r_hi, r_i;
    logic            r_hit;
    t_entry          r_hent;
    logic [7:0]      r_orig, r_before;
    logic            r_undo_put;
    logic [RW-1:0]   r_run;
    logic [OFW-1:0]  r_prev;

    logic            e_we, l_we;
    logic [PW-1:0]   e_waddr, e_raddr;
    t_entry          e_wdata, e_rdata;
    logic [UW-1:0]   l_waddr, l_raddr;
    t_log            l_wdata, l_rdata;

    bpo_ram #(.WIDTH(EW), .DEPTH(PATCH_DEPTH)) u_etab (
        .i_clk(i_clk), .i_we(e_we), .i_waddr(e_waddr), .i_wdata(e_wdata),
        .i_raddr(e_raddr), .o_rdata(e_rdata));
    bpo_ram #(.WIDTH(EW), .DEPTH(UNDO_DEPTH)) u_ltab (
        .i_clk(i_clk), .i_we(l_we), .i_waddr(l_waddr), .i_wdata(l_wdata),
        .i_raddr(l_raddr), .o_rdata(l_rdata));

    logic [CW-1:0] w_mid;
    assign w_mid = r_lo + ((r_hi - r_lo) >> 1);

    assign pready = 1'b1;
    always_comb begin
        prdata = '0;
        if (paddr[3] == ADDR_RO) prdata = {63'd0, r_ro};
        else                      prdata = r_size;
    end

    assign o_stall = (r_state != S_IDLE) || (o_valid && i_stall);

    logic [7:0] w_put_val, w_put_orig;

    always_comb begin
        e_we = 1'b0; e_waddr = '0; e_wdata = '0; e_raddr = '0;
        l_we = 1'b0; l_waddr = r_lcnt[UW-1:0]; l_wdata = '0;
        l_raddr = r_lcnt[UW-1:0] - 1'b1;
        unique case (r_state)
            // address held over the wait cycle of the registered read
            S_SRCH, S_SRD: e_raddr = w_mid[PW-1:0];
            S_HRD:   e_raddr = r_lo[PW-1:0];
            S_DELRD: e_raddr = PW'(r_i + 1'b1);
            S_DELWR: begin
                e_we = 1'b1; e_waddr = r_i[PW-1:0]; e_wdata = e_rdata;
            end
            S_INSRD: e_raddr = PW'(r_i - 1'b1);
            S_INSWR: begin
                e_we = 1'b1; e_waddr = r_i[PW-1:0]; e_wdata = e_rdata;
            end
            S_INSPUT: begin
                e_we = 1'b1; e_waddr = r_lo[PW-1:0];
                e_wdata = '{off: r_off, orig: r_orig, val: r_before};
            end
            S_UPD: begin
                e_we = 1'b1; e_waddr = r_lo[PW-1:0];
                e_wdata = '{off: r_hent.off, orig: r_hent.orig, val: r_before};
            end
            S_FRD, S_FWAIT: e_raddr = r_i[PW-1:0];
            S_DEC: begin
                // a full log must not wrap onto its first entry
                l_we = (r_func == F_EDIT) && r_undo_put &&
                       (r_lcnt < LCW'(UNDO_DEPTH));
                l_wdata = '{off: r_off, prior: w_put_val, orig: w_put_orig};
            end
            default: ;
        endcase
    end

    // edit side values: value before edit and original
    assign w_put_val  = r_hit ? r_hent.val : r_bb;
    assign w_put_orig = r_hit ? r_hent.orig : r_bb;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_ro <= 1'b0;
            r_size <= '0;
            r_ecnt <= '0;
            r_lcnt <= '0;
            o_valid <= 1'b0;
        end else begin
            if (psel && penable && pwrite) begin
                if (paddr[3] == ADDR_RO) r_ro <= pwdata[0];
                else                      r_size <= pwdata;
            end
            if (o_valid && !i_stall && r_state != S_OUT) o_valid <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (i_valid && !o_stall) begin
                        r_func <= i_func; r_off <= i_offset; r_nb <= i_new_byte;
                        r_bb <= i_base_byte; r_bs <= i_base_status;
                        r_lo <= '0; r_hi <= r_ecnt; r_hit <= 1'b0;
                        o_status <= ST_OK; o_data_byte <= '0; o_flush_offset <= '0;
                        o_run_start <= 1'b0; o_last <= 1'b1;
                        o_pending_count <= 7'(r_ecnt);
                        r_i <= '0; r_run <= '0;
                        unique case (t_func'(i_func))
                            F_READ, F_EDIT: begin
                                if ({1'b0, i_offset} >= r_size ||
                                    (i_func == F_EDIT && r_ro)) begin
                                    o_status <= ST_ERR; r_state <= S_OUT;
                                end else r_state <= S_SRCH;
                            end
                            F_UNDO: begin
                                if (r_lcnt == '0) begin
                                    o_status <= ST_EMPTY; r_state <= S_OUT;
                                end else r_state <= S_LRD;
                            end
                            F_FLUSH: begin
                                if (r_ro) begin
                                    o_status <= ST_ERR; r_state <= S_OUT;
                                end else if (r_ecnt == '0) begin
                                    r_lcnt <= '0; o_pending_count <= '0;
                                    r_state <= S_OUT;
                                end else r_state <= S_FRD;
                            end
                            default: r_state <= S_OUT;
                        endcase
                    end
                end
                S_LRD: r_state <= S_LWAIT;
                S_LWAIT: begin
                    r_off <= l_rdata.off; r_nb <= l_rdata.prior;
                    r_orig <= l_rdata.orig;
                    r_state <= S_SRCH;
                end
                S_SRCH: r_state <= (r_lo < r_hi) ? S_SRD : S_HRD;
                S_SRD: r_state <= S_SCHK;
                S_SCHK: begin
                    if (e_rdata.off < r_off) r_lo <= w_mid + 1'b1;
                    else                     r_hi <= w_mid;
                    r_state <= S_SRCH;
                end
                S_HRD: r_state <= S_HCHK;
                S_HCHK: begin
                    r_hent <= e_rdata;
                    r_hit <= (r_lo < r_ecnt) && (e_rdata.off == r_off);
                    r_state <= (r_func == F_UNDO) ? S_UDEC : S_DEC;
                    r_undo_put <= 1'b0;
                    if (r_func == F_EDIT) begin
                        r_undo_put <= 1'b1;
                    end
                end
                S_DEC: begin
                    r_state <= S_OUT;
                    if (r_func == F_READ) begin
                        if (r_hit) o_data_byte <= r_hent.val;
                        else if (r_bs == 2'd0) o_data_byte <= r_bb;
                        else o_status <= (r_bs == 2'd1) ? ST_UNAV : ST_ERR;
                    end else if (!r_hit && r_bs != 2'd0) begin
                        o_status <= ST_ERR;
                    end else if (w_put_val == r_nb) begin
                        o_status <= ST_OK;
                    end else if (r_lcnt >= LCW'(UNDO_DEPTH) ||
                                 (!r_hit && r_nb != w_put_orig &&
                                  r_ecnt >= CW'(PATCH_DEPTH))) begin
                        o_status <= ST_ERR;
                    end else begin
                        r_lcnt <= r_lcnt + 1'b1;
                        r_orig <= w_put_orig; r_before <= r_nb;
                        r_state <= S_UPD;
                        if (r_nb == w_put_orig) begin
                            r_state <= r_hit ? S_DELRD : S_OUT;
                            r_i <= r_lo;
                            if (r_hit) r_ecnt <= r_ecnt - 1'b1;
                        end else if (!r_hit) begin
                            r_i <= r_ecnt; r_ecnt <= r_ecnt + 1'b1;
                            r_state <= S_INSRD;
                        end
                        o_pending_count <= 7'(r_ecnt);
                    end
                end
                S_UDEC: begin
                    r_state <= S_OUT;
                    r_before <= r_nb;
                    if (r_nb == r_orig) begin
                        if (r_hit) begin
                            r_i <= r_lo; r_ecnt <= r_ecnt - 1'b1;
                            r_state <= S_DELRD;
                        end
                        r_lcnt <= r_lcnt - 1'b1;
                    end else if (r_hit) begin
                        r_lcnt <= r_lcnt - 1'b1; r_state <= S_UPD;
                    end else if (r_ecnt >= CW'(PATCH_DEPTH)) begin
                        o_status <= ST_ERR;
                    end else begin
                        r_lcnt <= r_lcnt - 1'b1;
                        r_i <= r_ecnt; r_ecnt <= r_ecnt + 1'b1;
                        r_state <= S_INSRD;
                    end
                end
                S_UPD: begin
                    o_pending_count <= 7'(r_ecnt); r_state <= S_OUT;
                end
                // delete: entry i takes entry i+1 while i+1 < old count
                S_DELRD: begin
                    if (r_i + 1'b1 <= r_ecnt) r_state <= S_DELWR;
                    else begin
                        o_pending_count <= 7'(r_ecnt); r_state <= S_OUT;
                    end
                end
                S_DELWR: begin
                    r_i <= r_i + 1'b1; r_state <= S_DELRD;
                end
                // insert: shift up from the end down to the slot
                S_INSRD: begin
                    if (r_i > r_lo) r_state <= S_INSWR;
                    else r_state <= S_INSPUT;
                end
                S_INSWR: begin
                    r_i <= r_i - 1'b1; r_state <= S_INSRD;
                end
                S_INSPUT: begin
                    o_pending_count <= 7'(r_ecnt); r_state <= S_OUT;
                end
                S_FRD: if (!o_valid || !i_stall) r_state <= S_FWAIT;
                S_FWAIT: r_state <= S_FEMIT;
                S_FEMIT: begin
                    logic st;
                    st = (r_i == '0) || (r_run >= RW'(MAX_RUN)) ||
                         (e_rdata.off != r_prev + 1'b1);
                    r_run <= st ? RW'(1) : r_run + 1'b1;
                    r_prev <= e_rdata.off;
                    o_valid <= 1'b1;
                    o_status <= ST_OK; o_data_byte <= e_rdata.val;
                    o_flush_offset <= e_rdata.off; o_run_start <= st;
                    o_pending_count <= '0;
                    o_last <= (r_i + 1'b1 == r_ecnt);
                    if (r_i + 1'b1 == r_ecnt) begin
                        r_ecnt <= '0; r_lcnt <= '0; r_state <= S_IDLE;
                    end else begin
                        r_i <= r_i + 1'b1; r_state <= S_FRD;
                    end
                end
                S_OUT: begin
                    if (!o_valid || !i_stall) begin
                        o_valid <= 1'b1; r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    `ASSERT_IMPLIES(a_cnt_bound, i_clk, i_rst_n, 1'b1, r_ecnt <= CW'(PATCH_DEPTH))
    `ASSERT_IMPLIES(a_log_bound, i_clk, i_rst_n, 1'b1, r_lcnt <= LCW'(UNDO_DEPTH))
    `ASSERT_NEXT(a_hold, i_clk, i_rst_n, o_valid && i_stall, o_valid && $stable(o_status))
    `ASSERT_IMPLIES(a_busy, i_clk, i_rst_n, r_state != S_IDLE, o_stall)
endmodule
